FILE: design/frc_pkg.sv
// Package for the framed response CRC checker.
// Holds command, status and register codes, item structs and the CRC and hex helpers.
// No dependencies; every other design file uses it.
package frc_pkg;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int TAIL_LEN = 4;

    localparam logic [WORD_W-1:0] CRC_POLY   = 16'h1021;
    localparam logic [BYTE_W-1:0] CLOSE_BRACE = 8'h7D;
    localparam logic [WORD_W-1:0] COUNT_MAX  = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] STOP_MARKER_RST   = 8'd3;
    localparam logic [WORD_W-1:0] CRC_SEED_RST      = 16'hFFFF;
    localparam logic [WORD_W-1:0] TIMEOUT_TICKS_RST = 16'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARM  = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CRC_OK    = 3'd0,
        ST_NO_CRC    = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_TIMEOUT   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER  = 2'd0,
        REG_STOP_MARKER   = 2'd1,
        REG_CRC_SEED      = 2'd2,
        REG_TIMEOUT_TICKS = 2'd3
    } cfg_reg_t;

    // Item held in the input register
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    // Result handed from the frame logic to the output register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   received_crc;
        logic [WORD_W-1:0]   calc_crc;
        logic [WORD_W-1:0]   payload_length;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    // One byte of CRC-16, MSB first, no reflection
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[WORD_W-1])
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[WORD_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // Decode one ASCII hex character
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] ch);
        hex_t h;
        h.ok     = 1'b0;
        h.nibble = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.ok     = 1'b1;
            h.nibble = 4'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            h.ok     = 1'b1;
            h.nibble = 4'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            h.ok     = 1'b1;
            h.nibble = 4'(ch - 8'h37);
        end
        return h;
    endfunction

endpackage

FILE: design/frc_if.sv
// Valid/ready channel interfaces for the framed response CRC checker.
// Depends on frc_pkg for field widths.
interface frc_req_if;
    logic                        valid;
    logic                        ready;
    logic [frc_pkg::CMD_W-1:0]   command;
    logic [frc_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface frc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [frc_pkg::STATUS_W-1:0]  status;
    logic [frc_pkg::WORD_W-1:0]    received_crc;
    logic [frc_pkg::WORD_W-1:0]    calc_crc;
    logic [frc_pkg::WORD_W-1:0]    payload_length;

    modport source (output valid, output status, output received_crc,
                    output calc_crc, output payload_length, input ready);
    modport sink   (input valid, input status, input received_crc,
                    input calc_crc, input payload_length, output ready);
endinterface

FILE: design/framed_response_crc_checker_core.sv
// Top level of the framed response CRC checker.
// Depends on frc_pkg, frc_if, frc_in_stage, frc_frame and frc_out_stage.
//
// Takes one item (arm, received byte or tick) per clock and answers with at
// most one result per item: ok, no checksum, mismatch, malformed or timeout.
// An accepted item lands in an input register; from there the frame
// logic updates the byte count, the four-byte trailer window and the CRC-16
// (one full byte of the 0x1021 polynomial per cycle) and, for a stop byte or
// an expiring tick, writes the result register. A result thus passes the
// input register and then the result register before it shows on rsp; items
// flow at one per cycle; input stalls only while the result register is full
// and not being taken and the pending item would produce another result.
module framed_response_crc_checker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    frc_req_if.sink                       req,
    frc_rsp_if.source                     rsp,
    input  logic                          cfg_wr_en,
    input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frc_pkg::WORD_W-1:0]    cfg_data
);

    frc_pkg::item_t   item;
    frc_pkg::result_t res;
    logic             take;
    logic             res_valid;
    logic             slot_free;

    frc_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .item  (item)
    );

    frc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .slot_free (slot_free),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    frc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .rsp       (rsp)
    );

endmodule

FILE: design/frc_in_stage.sv
// Input register of the framed response CRC checker.
// Depends on frc_pkg and frc_req_if.
module frc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    frc_req_if.sink         req,
    input  logic            take,
    output frc_pkg::item_t  item
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [frc_pkg::CMD_W-1:0]  command_reg;
    logic [frc_pkg::BYTE_W-1:0] rx_byte_reg;
    logic                       load;

    // Accept a new item when the register is empty or drains this cycle
    assign req.ready = !valid_reg || take;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload of the accepted item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            command_reg <= req.command;
            rx_byte_reg <= req.rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.command = command_reg;
    assign item.rx_byte = rx_byte_reg;

endmodule

FILE: design/frc_frame.sv
// Frame state, configuration registers and frame judgment.
// Depends on frc_pkg.
module frc_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frc_pkg::WORD_W-1:0]    cfg_data,
    input  frc_pkg::item_t                item,
    input  logic                          slot_free,
    output logic                          take,
    output logic                          res_valid,
    output frc_pkg::result_t              res
);

    // Configuration registers
    logic [frc_pkg::BYTE_W-1:0] start_marker_reg;
    logic [frc_pkg::BYTE_W-1:0] stop_marker_reg;
    logic [frc_pkg::WORD_W-1:0] crc_seed_reg;
    logic [frc_pkg::WORD_W-1:0] timeout_ticks_reg;

    // Receive state
    logic [frc_pkg::BYTE_W-1:0] tail_reg  [frc_pkg::TAIL_LEN];
    logic [frc_pkg::BYTE_W-1:0] tail_next [frc_pkg::TAIL_LEN];
    logic [frc_pkg::WORD_W-1:0] count_reg, count_next;
    logic [frc_pkg::WORD_W-1:0] crc_reg, crc_next;
    logic [frc_pkg::WORD_W-1:0] tick_reg, tick_next;
    logic                       receiving_reg, receiving_next;

    logic [frc_pkg::WORD_W-1:0] tick_inc;
    logic                       is_start, is_stop, timed_out;
    logic                       produces;
    frc_pkg::hex_t              hex [frc_pkg::TAIL_LEN];
    logic                       hex_ok;
    logic [frc_pkg::WORD_W-1:0] rx_crc;
    frc_pkg::result_t           judged;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= frc_pkg::START_MARKER_RST;
            stop_marker_reg   <= frc_pkg::STOP_MARKER_RST;
            crc_seed_reg      <= frc_pkg::CRC_SEED_RST;
            timeout_ticks_reg <= frc_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (frc_pkg::cfg_reg_t'(cfg_index))
                frc_pkg::REG_START_MARKER:  start_marker_reg  <= cfg_data[frc_pkg::BYTE_W-1:0];
                frc_pkg::REG_STOP_MARKER:   stop_marker_reg   <= cfg_data[frc_pkg::BYTE_W-1:0];
                frc_pkg::REG_CRC_SEED:      crc_seed_reg      <= cfg_data;
                frc_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the current item against the state
    assign is_start  = item.rx_byte == start_marker_reg;
    assign is_stop   = !is_start && (item.rx_byte == stop_marker_reg);
    assign tick_inc  = (tick_reg == frc_pkg::COUNT_MAX) ? tick_reg : tick_reg + 1'b1;
    assign timed_out = tick_inc >= timeout_ticks_reg;

    always_comb
    begin
        produces = 1'b0;
        if (receiving_reg)
        begin
            case (frc_pkg::cmd_t'(item.command))
                frc_pkg::CMD_BYTE: produces = is_stop;
                frc_pkg::CMD_TICK: produces = timed_out;
                default:           produces = 1'b0;
            endcase
        end
    end

    // Advance unless a result has no room in the output register
    assign take      = item.valid && (!produces || slot_free);
    assign res_valid = take && produces;

    // Decode the trailer as four hex digits
    always_comb
    begin
        hex_ok = 1'b1;
        for (int i = 0; i < frc_pkg::TAIL_LEN; i++)
        begin
            hex[i] = frc_pkg::hex_decode(tail_reg[i]);
            hex_ok = hex_ok && hex[i].ok;
        end
        rx_crc = {hex[0].nibble, hex[1].nibble, hex[2].nibble, hex[3].nibble};
    end

    // Judge the frame at the stop byte
    always_comb
    begin
        judged.status         = frc_pkg::ST_MALFORMED;
        judged.received_crc   = '0;
        judged.calc_crc       = '0;
        judged.payload_length = count_reg;
        if (count_reg == '0)
            judged.status = frc_pkg::ST_MALFORMED;
        else if (tail_reg[frc_pkg::TAIL_LEN-1] == frc_pkg::CLOSE_BRACE)
            judged.status = frc_pkg::ST_NO_CRC;
        else if (count_reg <= frc_pkg::WORD_W'(frc_pkg::TAIL_LEN) || !hex_ok)
            judged.status = frc_pkg::ST_MALFORMED;
        else
        begin
            judged.status         = (rx_crc == crc_reg) ? frc_pkg::ST_CRC_OK
                                                        : frc_pkg::ST_MISMATCH;
            judged.received_crc   = rx_crc;
            judged.calc_crc       = crc_reg;
            judged.payload_length = (count_reg == frc_pkg::COUNT_MAX)
                                    ? count_reg
                                    : count_reg - frc_pkg::WORD_W'(frc_pkg::TAIL_LEN);
        end
    end

    // Pick the result for this item
    always_comb
    begin
        res = judged;
        if (frc_pkg::cmd_t'(item.command) == frc_pkg::CMD_TICK)
        begin
            res.status         = frc_pkg::ST_TIMEOUT;
            res.received_crc   = '0;
            res.calc_crc       = '0;
            res.payload_length = count_reg;
        end
    end

    // Next state of the receiver
    always_comb
    begin
        tail_next      = tail_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        tick_next      = tick_reg;
        receiving_next = receiving_reg;
        case (frc_pkg::cmd_t'(item.command))
            frc_pkg::CMD_ARM:
            begin
                for (int i = 0; i < frc_pkg::TAIL_LEN; i++)
                    tail_next[i] = '0;
                count_next     = '0;
                crc_next       = crc_seed_reg;
                tick_next      = '0;
                receiving_next = 1'b1;
            end
            frc_pkg::CMD_BYTE:
            begin
                if (receiving_reg && !is_start)
                begin
                    if (is_stop)
                        receiving_next = 1'b0;
                    else
                    begin
                        if (count_reg >= frc_pkg::WORD_W'(frc_pkg::TAIL_LEN))
                            crc_next = frc_pkg::crc_byte(crc_reg, tail_reg[0]);
                        for (int i = 0; i < frc_pkg::TAIL_LEN - 1; i++)
                            tail_next[i] = tail_reg[i+1];
                        tail_next[frc_pkg::TAIL_LEN-1] = item.rx_byte;
                        if (count_reg != frc_pkg::COUNT_MAX)
                            count_next = count_reg + 1'b1;
                    end
                end
            end
            frc_pkg::CMD_TICK:
            begin
                if (receiving_reg)
                begin
                    tick_next = tick_inc;
                    if (timed_out)
                        receiving_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < frc_pkg::TAIL_LEN; i++)
                tail_reg[i] <= '0;
            count_reg     <= '0;
            crc_reg       <= frc_pkg::CRC_SEED_RST;
            tick_reg      <= '0;
            receiving_reg <= 1'b0;
        end
        else if (take)
        begin
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            tick_reg      <= tick_next;
            receiving_reg <= receiving_next;
        end
    end

endmodule

FILE: design/frc_out_stage.sv
// Result register of the framed response CRC checker.
// Depends on frc_pkg and frc_rsp_if.
module frc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  frc_pkg::result_t  res,
    output logic              slot_free,
    frc_rsp_if.source         rsp
);

    logic             valid_reg;
    logic             valid_next;
    frc_pkg::result_t res_reg;

    // Room for a new result when empty or drained this cycle
    assign slot_free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign rsp.valid          = valid_reg;
    assign rsp.status         = res_reg.status;
    assign rsp.received_crc   = res_reg.received_crc;
    assign rsp.calc_crc       = res_reg.calc_crc;
    assign rsp.payload_length = res_reg.payload_length;

endmodule

FILE: design/frc_checker.sv
// Port-level checks for the framed response CRC checker, bound to the top level.
// Depends on frc_pkg and framed_response_crc_checker_core.
module frc_port_checks (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [frc_pkg::STATUS_W-1:0] rsp_status,
    input logic [frc_pkg::WORD_W-1:0]   rsp_received_crc,
    input logic [frc_pkg::WORD_W-1:0]   rsp_calc_crc
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("result dropped while stalled");

    // Status stays within its codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= frc_pkg::ST_TIMEOUT)
        else $error("status code out of range");

    // Unchecked frames carry zero CRC fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == frc_pkg::ST_NO_CRC ||
                      rsp_status == frc_pkg::ST_MALFORMED ||
                      rsp_status == frc_pkg::ST_TIMEOUT)
        |-> rsp_received_crc == '0 && rsp_calc_crc == '0)
        else $error("CRC fields not zero on unchecked frame");

    // Ok means the CRCs agree
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == frc_pkg::ST_CRC_OK
        |-> rsp_received_crc == rsp_calc_crc)
        else $error("ok status with differing CRCs");

    // Mismatch means the CRCs differ
    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == frc_pkg::ST_MISMATCH
        |-> rsp_received_crc != rsp_calc_crc)
        else $error("mismatch status with equal CRCs");

endmodule

bind framed_response_crc_checker_core frc_port_checks u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_received_crc (rsp.received_crc),
    .rsp_calc_crc     (rsp.calc_crc)
);
